[src/sbip_pkg.sv]
// Shared types, codes and constants for the sample buffer playback core.
`default_nettype none
package sbip_pkg;

	localparam int DEPTH_DEF       = 4096;
	localparam int SAMPLE_BITS_DEF = 16;

	localparam int ACTION_W  = 3;
	localparam int INDEX_W   = 12;
	localparam int SAMPLE_W  = 16;
	localparam int STEP_W    = 24;
	localparam int POS_W     = 13;
	localparam int LENGTH_W  = 13;
	localparam int FRAC_W    = 16;

	localparam logic [ACTION_W-1:0] ACT_REWIND  = 3'd0;
	localparam logic [ACTION_W-1:0] ACT_WRITE   = 3'd1;
	localparam logic [ACTION_W-1:0] ACT_READ    = 3'd2;
	localparam logic [ACTION_W-1:0] ACT_APPEND  = 3'd3;
	localparam logic [ACTION_W-1:0] ACT_NEXT    = 3'd4;
	localparam logic [ACTION_W-1:0] ACT_STRETCH = 3'd5;

	typedef struct packed {
		logic [ACTION_W-1:0]       action;
		logic [INDEX_W-1:0]        sample_index;
		logic signed [SAMPLE_W-1:0] sample_in;
		logic [STEP_W-1:0]         rate_step;
	} in_item_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample_out;
		logic [POS_W-1:0]          position;
		logic                      at_end;
	} out_item_t;

endpackage
`default_nettype wire

[src/sbip_lerp.sv]
// Iterative shift-add interpolator between two stored samples.
`default_nettype none
module sbip_lerp import sbip_pkg::*; #(
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   start,
	input  wire logic [SAMPLE_BITS-1:0] a,
	input  wire logic [SAMPLE_BITS-1:0] b,
	input  wire logic [FRAC_W-1:0]      frac,
	output logic                        busy,
	output logic [SAMPLE_BITS-1:0]      result
);

	localparam int ACC_W = SAMPLE_BITS + FRAC_W + 2;
	localparam int CNT_W = $clog2(FRAC_W);
	localparam logic [SAMPLE_BITS-1:0] BIAS = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
	localparam logic [ACC_W-1:0] ROUND = ACC_W'(1) << (FRAC_W - 1);
	localparam logic [CNT_W-1:0] LAST = CNT_W'(FRAC_W - 1);

	logic [SAMPLE_BITS-1:0] ua, ub;
	logic [ACC_W-1:0]       acc_q, md_q;
	logic [FRAC_W-1:0]      fr_q;
	logic [CNT_W-1:0]       cnt_q;
	logic                   run_q;

	// Offset-binary view keeps the blend in unsigned arithmetic
	assign ua = a ^ BIAS;
	assign ub = b ^ BIAS;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			run_q <= 1'b1;
			cnt_q <= '0;
		end else if (run_q) begin
			cnt_q <= cnt_q + CNT_W'(1);
			if (cnt_q == LAST) begin
				run_q <= 1'b0;
			end
		end
	end

	// acc = a*2^16 + half + (b-a)*f, one fraction bit per cycle
	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= (ACC_W'(ua) << FRAC_W) + ROUND;
			md_q  <= ACC_W'(ub) - ACC_W'(ua);
			fr_q  <= frac;
		end else if (run_q) begin
			if (fr_q[0]) begin
				acc_q <= acc_q + md_q;
			end
			md_q <= md_q << 1;
			fr_q <= fr_q >> 1;
		end
	end

	assign busy   = run_q;
	assign result = acc_q[FRAC_W +: SAMPLE_BITS] ^ BIAS;

endmodule
`default_nettype wire

[src/sample_buffer_interp_playback_core.sv]
// Top level of the sample buffer with linear-interpolation playback.
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+---------------------------------------
//  in      | into core | in_valid / in_ready | in_item: action, index, sample, rate step
//  out     | from core | out_valid/out_ready | out_item: sample, position, at_end
//  cfg     | into core | cfg_we              | cfg_data: active length
//
// Every action but an interpolating stretched read goes from the idle state straight to
// the output state. That read passes through two store reads, a start state, 16 shift-add
// steps of the interpolator, a state to see it finish and one to load the output.
// Reset clears the position and sets the active length to DEPTH; the store keeps
// whatever it held. A finished result waits in the output register while the next
// item is taken; only a result whose predecessor is still unread stalls the core.
`default_nettype none
module sample_buffer_interp_playback_core import sbip_pkg::*; #(
	parameter int DEPTH       = DEPTH_DEF,
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire in_item_t            in_item,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output out_item_t                out_item,
	input  wire logic                cfg_we,
	input  wire logic [LENGTH_W-1:0] cfg_data
);

	localparam int LEN_W  = $clog2(DEPTH + 1);
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int CMP_W  = ((LEN_W > LENGTH_W) ? LEN_W : LENGTH_W) + 2;
	localparam int SUM_W  = ((LEN_W + FRAC_W > STEP_W) ? LEN_W + FRAC_W : STEP_W) + 1;
	localparam logic [SUM_W-1:0] POS_MAX = SUM_W'(DEPTH) << FRAC_W;
	localparam logic [CMP_W-1:0] DEPTH_X = CMP_W'(DEPTH);

	// sequencer states
	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_RDB  = 3'd1;
	localparam logic [2:0] S_GO   = 3'd2;
	localparam logic [2:0] S_MUL  = 3'd3;
	localparam logic [2:0] S_OUT  = 3'd4;

	// where the result sample comes from
	localparam logic [1:0] SRC_ZERO = 2'd0;
	localparam logic [1:0] SRC_MEM  = 2'd1;
	localparam logic [1:0] SRC_LERP = 2'd2;

	logic [2:0]             state_q, state_d;
	logic [1:0]             src_q, src_d;
	logic [LEN_W-1:0]       len_q;
	logic [LEN_W-1:0]       pi_q;
	logic [FRAC_W-1:0]      frac_q;
	logic [STEP_W-1:0]      step_q;
	logic [SAMPLE_BITS-1:0] a_q;
	logic [SAMPLE_BITS-1:0] mem_q;
	logic [SAMPLE_BITS-1:0] mem [DEPTH];
	logic                   out_valid_q;
	out_item_t              out_item_q;

	logic                   accept;
	logic                   rd_en, wr_en, advance, rewind;
	logic [ADDR_W-1:0]      rd_addr, wr_addr;
	logic [SAMPLE_BITS-1:0] wr_data;
	logic [CMP_W-1:0]       idx_x, len_x, pi_x, cfg_x;
	logic                   idx_ok, pi_ok, len_one, lerp_ok, last_ok;
	logic [SUM_W-1:0]       pos_sum;
	logic                   lerp_start, lerp_busy;
	logic [SAMPLE_BITS-1:0] lerp_res;
	logic [SAMPLE_BITS-1:0] res_raw;
	logic                   load_out;

	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid && in_ready;

	// range checks against the active length
	assign idx_x   = CMP_W'(in_item.sample_index);
	assign len_x   = CMP_W'(len_q);
	assign pi_x    = CMP_W'(pi_q);
	assign cfg_x   = CMP_W'(cfg_data);
	assign idx_ok  = idx_x < len_x;
	assign pi_ok   = pi_x < len_x;
	assign len_one = len_x == CMP_W'(1);
	assign lerp_ok = (len_x > CMP_W'(1)) && (pi_x + CMP_W'(2) <= len_x);
	assign last_ok = (len_x > CMP_W'(1)) && (pi_x + CMP_W'(1) == len_x);

	// decode the accepted item; reads and writes go to the store in the same cycle
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = ADDR_W'(pi_q);
		wr_en   = 1'b0;
		wr_addr = ADDR_W'(in_item.sample_index);
		wr_data = SAMPLE_BITS'($unsigned(in_item.sample_in));
		advance = 1'b0;
		rewind  = 1'b0;
		src_d   = SRC_ZERO;
		state_d = S_OUT;
		if (state_q == S_RDB) begin
			rd_en   = 1'b1;
			rd_addr = ADDR_W'(pi_q) + ADDR_W'(1);
		end else if (accept) begin
			case (in_item.action)
				ACT_REWIND: begin
					rewind = 1'b1;
				end
				ACT_WRITE: begin
					wr_en = idx_ok;
				end
				ACT_READ: begin
					rd_en   = idx_ok;
					rd_addr = ADDR_W'(in_item.sample_index);
					src_d   = idx_ok ? SRC_MEM : SRC_ZERO;
				end
				ACT_APPEND: begin
					wr_en   = pi_ok;
					wr_addr = ADDR_W'(pi_q);
					advance = pi_ok;
				end
				ACT_NEXT: begin
					rd_en   = pi_ok;
					advance = pi_ok;
					src_d   = pi_ok ? SRC_MEM : SRC_ZERO;
				end
				ACT_STRETCH: begin
					if (len_one) begin
						rd_en   = 1'b1;
						rd_addr = '0;
						src_d   = SRC_MEM;
					end else if (lerp_ok) begin
						rd_en   = 1'b1;
						src_d   = SRC_LERP;
						state_d = S_RDB;
					end else if (last_ok) begin
						// last sample: no blend, step onto the end
						rd_en   = 1'b1;
						advance = 1'b1;
						src_d   = SRC_MEM;
					end
				end
				default: begin
					src_d = SRC_ZERO;
				end
			endcase
		end
	end

	// sample store: one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			mem_q <= mem[rd_addr];
		end
	end

	// hold the first sample and the rate step while the second one is fetched
	always_ff @(posedge clk) begin
		if (accept) begin
			step_q <= in_item.rate_step;
		end
		if (state_q == S_RDB) begin
			a_q <= mem_q;
		end
	end

	// advance the position by the rate step, saturating at the end of the store
	assign pos_sum    = SUM_W'({pi_q, frac_q}) + SUM_W'(step_q);
	assign lerp_start = (state_q == S_GO);

	sbip_lerp #(
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_lerp (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (lerp_start),
		.a      (a_q),
		.b      (mem_q),
		.frac   (frac_q),
		.busy   (lerp_busy),
		.result (lerp_res)
	);

	assign load_out = (state_q == S_OUT) && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			src_q       <= SRC_ZERO;
			len_q       <= LEN_W'(DEPTH);
			pi_q        <= '0;
			frac_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				// clamp to the store depth and rewind
				len_q  <= (cfg_x > DEPTH_X) ? LEN_W'(DEPTH) : LEN_W'(cfg_data);
				pi_q   <= '0;
				frac_q <= '0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= state_d;
						src_q   <= src_d;
						if (rewind) begin
							pi_q   <= '0;
							frac_q <= '0;
						end else if (advance) begin
							pi_q   <= pi_q + LEN_W'(1);
							frac_q <= '0;
						end
					end
				end
				S_RDB: begin
					state_q <= S_GO;
				end
				S_GO: begin
					state_q <= S_MUL;
					if (pos_sum > POS_MAX) begin
						pi_q   <= LEN_W'(DEPTH);
						frac_q <= '0;
					end else begin
						pi_q   <= pos_sum[FRAC_W +: LEN_W];
						frac_q <= pos_sum[FRAC_W-1:0];
					end
				end
				S_MUL: begin
					if (!lerp_busy) begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (load_out) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		case (src_q)
			SRC_MEM:  res_raw = mem_q;
			SRC_LERP: res_raw = lerp_res;
			default:  res_raw = '0;
		endcase
	end

	// drop the finished result into the output register
	always_ff @(posedge clk) begin
		if (load_out) begin
			out_item_q.sample_out <= SAMPLE_W'(res_raw);
			out_item_q.position   <= POS_W'(pi_q);
			out_item_q.at_end     <= (len_q == '0) || (pi_x >= len_x);
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

endmodule
`default_nettype wire
